FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

FILE: rtl/mdec_pkg.sv
// ----------------------------------------------------------------------------
// mdec_pkg
// Types, constants and the code table of the Morse decoder.
// ----------------------------------------------------------------------------
package mdec_pkg;

  // Token limits
  localparam int MaxSymbols = 7;
  localparam int CntW       = $clog2(MaxSymbols + 1);
  localparam int PatW       = 7;
  localparam int ByteW      = 8;
  localparam int CharW      = 7;

  // Byte codes
  localparam logic [ByteW-1:0] DotByte   = 8'h2E;
  localparam logic [ByteW-1:0] DashByte  = 8'h2D;
  localparam logic [ByteW-1:0] SlashByte = 8'h2F;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;
  localparam logic [ByteW-1:0] TabByte   = 8'h09;
  localparam logic [ByteW-1:0] CrByte    = 8'h0D;
  localparam logic [CharW-1:0] SpaceChar = 7'h20;

  // Closed token handed from front to back
  typedef struct packed {
    logic            slash;
    logic [CntW-1:0] len;
    logic [PatW-1:0] pattern;
  } tok_rec_t;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } lookup_t;

  // Code table: length and dot/dash bits (dash = 1, newest symbol in bit 0)
  function automatic lookup_t code_lookup(logic [CntW-1:0] len, logic [PatW-1:0] pat);
    lookup_t r;
    r.hit = 1'b1;
    r.ch  = '0;
    unique case ({len, pat})
      {3'd1, 7'b0000000}: r.ch = 7'h45; // E
      {3'd1, 7'b0000001}: r.ch = 7'h54; // T
      {3'd2, 7'b0000001}: r.ch = 7'h41; // A
      {3'd2, 7'b0000000}: r.ch = 7'h49; // I
      {3'd2, 7'b0000011}: r.ch = 7'h4D; // M
      {3'd2, 7'b0000010}: r.ch = 7'h4E; // N
      {3'd3, 7'b0000100}: r.ch = 7'h44; // D
      {3'd3, 7'b0000110}: r.ch = 7'h47; // G
      {3'd3, 7'b0000101}: r.ch = 7'h4B; // K
      {3'd3, 7'b0000111}: r.ch = 7'h4F; // O
      {3'd3, 7'b0000010}: r.ch = 7'h52; // R
      {3'd3, 7'b0000000}: r.ch = 7'h53; // S
      {3'd3, 7'b0000001}: r.ch = 7'h55; // U
      {3'd3, 7'b0000011}: r.ch = 7'h57; // W
      {3'd4, 7'b0001000}: r.ch = 7'h42; // B
      {3'd4, 7'b0001010}: r.ch = 7'h43; // C
      {3'd4, 7'b0000010}: r.ch = 7'h46; // F
      {3'd4, 7'b0000000}: r.ch = 7'h48; // H
      {3'd4, 7'b0000111}: r.ch = 7'h4A; // J
      {3'd4, 7'b0000100}: r.ch = 7'h4C; // L
      {3'd4, 7'b0000110}: r.ch = 7'h50; // P
      {3'd4, 7'b0001101}: r.ch = 7'h51; // Q
      {3'd4, 7'b0000001}: r.ch = 7'h56; // V
      {3'd4, 7'b0001001}: r.ch = 7'h58; // X
      {3'd4, 7'b0001011}: r.ch = 7'h59; // Y
      {3'd4, 7'b0001100}: r.ch = 7'h5A; // Z
      {3'd5, 7'b0011111}: r.ch = 7'h30; // 0
      {3'd5, 7'b0001111}: r.ch = 7'h31; // 1
      {3'd5, 7'b0000111}: r.ch = 7'h32; // 2
      {3'd5, 7'b0000011}: r.ch = 7'h33; // 3
      {3'd5, 7'b0000001}: r.ch = 7'h34; // 4
      {3'd5, 7'b0000000}: r.ch = 7'h35; // 5
      {3'd5, 7'b0010000}: r.ch = 7'h36; // 6
      {3'd5, 7'b0011000}: r.ch = 7'h37; // 7
      {3'd5, 7'b0011100}: r.ch = 7'h38; // 8
      {3'd5, 7'b0011110}: r.ch = 7'h39; // 9
      {3'd5, 7'b0010010}: r.ch = 7'h2F; // slash
      {3'd5, 7'b0010110}: r.ch = 7'h28; // open paren
      {3'd5, 7'b0001000}: r.ch = 7'h26; // ampersand
      {3'd5, 7'b0010001}: r.ch = 7'h3D; // equals
      {3'd5, 7'b0001010}: r.ch = 7'h2B; // plus
      {3'd5, 7'b0010100}: r.ch = 7'h7C; // bar
      {3'd5, 7'b0010011}: r.ch = 7'h7B; // open brace
      {3'd5, 7'b0011001}: r.ch = 7'h7D; // close brace
      {3'd5, 7'b0010101}: r.ch = 7'h2A; // asterisk
      {3'd6, 7'b0010101}: r.ch = 7'h2E; // full stop
      {3'd6, 7'b0110011}: r.ch = 7'h2C; // comma
      {3'd6, 7'b0001100}: r.ch = 7'h3F; // question mark
      {3'd6, 7'b0011110}: r.ch = 7'h27; // apostrophe
      {3'd6, 7'b0101011}: r.ch = 7'h21; // exclamation
      {3'd6, 7'b0101101}: r.ch = 7'h29; // close paren
      {3'd6, 7'b0111000}: r.ch = 7'h3A; // colon
      {3'd6, 7'b0101010}: r.ch = 7'h3B; // semicolon
      {3'd6, 7'b0100001}: r.ch = 7'h2D; // hyphen
      {3'd6, 7'b0001101}: r.ch = 7'h5F; // underscore
      {3'd6, 7'b0010010}: r.ch = 7'h22; // double quote
      {3'd6, 7'b0011010}: r.ch = 7'h40; // at sign
      {3'd6, 7'b0000101}: r.ch = 7'h23; // hash
      {3'd6, 7'b0111110}: r.ch = 7'h25; // percent
      {3'd6, 7'b0100010}: r.ch = 7'h5E; // caret
      {3'd6, 7'b0101100}: r.ch = 7'h3E; // greater than
      {3'd6, 7'b0010100}: r.ch = 7'h0A; // line feed
      {3'd7, 7'b0001001}: r.ch = 7'h24; // dollar
      {3'd7, 7'b0110110}: r.ch = 7'h7E; // tilde
      default:            r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mdec_front.sv
// ----------------------------------------------------------------------------
// mdec_front
// Classifies code bytes, builds the current token and hands closed tokens on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdec_front import mdec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] code_byte_i,
  input  logic             end_of_text_i,
  output logic             emit_o,
  output tok_rec_t         rec_o
);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_upd;
  logic [PatW-1:0] pat_q, pat_d, pat_upd;
  logic            slash_q, slash_d, slash_upd;
  logic            inv_q, inv_d, inv_upd;
  logic            is_space, is_sym, close;

  // Byte classes
  assign is_space = (code_byte_i == SpaceByte) ||
                    ((code_byte_i >= TabByte) && (code_byte_i <= CrByte));
  assign is_sym   = (code_byte_i == DotByte) || (code_byte_i == DashByte);

  // Token state after this word
  always_comb begin
    cnt_upd   = cnt_q;
    pat_upd   = pat_q;
    slash_upd = slash_q;
    inv_upd   = inv_q;
    if (is_space) begin
      // closes only, no change
    end else if (is_sym) begin
      if (slash_q || (cnt_q >= CntW'(MaxSymbols))) begin
        inv_upd = 1'b1;
      end else begin
        pat_upd = {pat_q[PatW-2:0], code_byte_i == DashByte};
        cnt_upd = cnt_q + CntW'(1);
      end
    end else if (code_byte_i == SlashByte) begin
      if (slash_q || (cnt_q != '0)) begin
        inv_upd = 1'b1;
      end
      slash_upd = 1'b1;
    end else begin
      inv_upd = 1'b1;
    end
  end

  // Close on whitespace or end of text; hand on only tokens that may print
  assign close  = is_space || end_of_text_i;
  assign emit_o = accept_i && close && !inv_upd && (slash_upd || (cnt_upd != '0));
  assign rec_o  = '{slash: slash_upd, len: cnt_upd, pattern: pat_upd};

  always_comb begin
    cnt_d   = cnt_q;
    pat_d   = pat_q;
    slash_d = slash_q;
    inv_d   = inv_q;
    if (accept_i) begin
      if (close) begin
        cnt_d   = '0;
        pat_d   = '0;
        slash_d = 1'b0;
        inv_d   = 1'b0;
      end else begin
        cnt_d   = cnt_upd;
        pat_d   = pat_upd;
        slash_d = slash_upd;
        inv_d   = inv_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pat_q   <= '0;
      slash_q <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      pat_q   <= pat_d;
      slash_q <= slash_d;
      inv_q   <= inv_d;
    end
  end

  // Held symbol count stays within the token limit
  `ASSERT_NEVER(a_cnt_limit, clk_i, rst_ni, cnt_q > CntW'(MaxSymbols))

endmodule

FILE: rtl/mdec_tok_queue.sv
// ----------------------------------------------------------------------------
// mdec_tok_queue
// Two-entry queue of closed tokens between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdec_tok_queue import mdec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tok_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output tok_rec_t rec_o,
  output logic     empty_o
);

  tok_rec_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Fill count never passes the depth, and a push is never offered when full
  `ASSERT_NEVER(a_tq_over, clk_i, rst_ni, cnt_q == 2'd3)
  `ASSERT_NEVER(a_tq_lost, clk_i, rst_ni, push_i && full_o)

endmodule

FILE: rtl/mdec_back.sv
// ----------------------------------------------------------------------------
// mdec_back
// Looks up closed tokens in the code table and queues the characters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdec_back import mdec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tq_empty_i,
  input  tok_rec_t         tq_rec_i,
  output logic             tq_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [CharW-1:0] text_char_o
);

  logic [CharW-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             rq_full, rq_push, rq_pop;
  lookup_t          res;

  // Table lookup of the token at the queue head; a lone slash is a space
  always_comb begin
    if (tq_rec_i.slash) begin
      res = '{hit: 1'b1, ch: SpaceChar};
    end else begin
      res = code_lookup(tq_rec_i.len, tq_rec_i.pattern);
    end
  end

  // Take a token when there is room for its character; misses are dropped
  assign rq_full  = (cnt_q == 2'd2);
  assign tq_pop_o = !tq_empty_i && !rq_full;
  assign rq_push  = tq_pop_o && res.hit;

  // Result queue
  assign empty_o     = (cnt_q == 2'd0);
  assign rq_pop      = pop_i && !empty_o;
  assign text_char_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ rq_push;
    rd_ptr_d = rd_ptr_q ^ rq_pop;
    cnt_d    = cnt_q + {1'b0, rq_push} - {1'b0, rq_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      mem_q[wr_ptr_q] <= res.ch;
    end
  end

  // A slash token always yields a space word in the queue
  `ASSERT_PROP(a_slash_space, clk_i, rst_ni,
               (tq_pop_o && tq_rec_i.slash) |=> (mem_q[$past(wr_ptr_q)] == SpaceChar))
  // Result fill count stays within depth
  `ASSERT_NEVER(a_rq_over, clk_i, rst_ni, cnt_q == 2'd3)

endmodule

FILE: rtl/morse_code_decoder.sv
// ----------------------------------------------------------------------------
// morse_code_decoder
// Splits a byte stream of Morse text into tokens and decodes them to ASCII.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | words
//  --------+-----------+-----------------+-----------------------------------
//  input   | in        | push / full     | code_byte_i[7:0], end_of_text_i
//  result  | out       | empty / pop     | text_char_o[6:0]
//
//  One code byte is taken every cycle while full is low; the front updates
//  the token register in that same cycle.
//  A closed token enters the token queue at the edge that takes the byte
//  closing it; the table lookup then moves its character from the queue
//  head into the result queue when there is room; the word is popped there.
//  full rises only when both two-entry queues have backed up behind pop.
//  Reset clears the token register and both queues; no clearing pass.
// ----------------------------------------------------------------------------
module morse_code_decoder import mdec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] code_byte_i,
  input  logic             end_of_text_i,
  output logic             empty,
  input  logic             pop,
  output logic [CharW-1:0] text_char_o
);

  logic     accept, emit, tq_empty, tq_pop;
  tok_rec_t emit_rec, head_rec;

  assign accept = push && !full;

  // Front: tokeniser
  mdec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .code_byte_i   (code_byte_i),
    .end_of_text_i (end_of_text_i),
    .emit_o        (emit),
    .rec_o         (emit_rec)
  );

  // Queue of closed tokens
  mdec_tok_queue u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .rec_i   (emit_rec),
    .full_o  (full),
    .pop_i   (tq_pop),
    .rec_o   (head_rec),
    .empty_o (tq_empty)
  );

  // Back: table lookup and result queue
  mdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tq_empty_i  (tq_empty),
    .tq_rec_i    (head_rec),
    .tq_pop_o    (tq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .text_char_o (text_char_o)
  );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives Morse text bytes into morse_code_decoder and checks every decoded
// character against a token model kept here, under random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench import mdec_pkg::*; ();

  localparam int NumItems   = 1900;
  localparam int IdlePct    = 28;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 12;
  localparam int SatCount   = 15;

  typedef struct packed {
    logic [ByteW-1:0] code;
    logic             eot;
  } code_item_t;

  // DUT ports
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             push          = 1'b0;
  logic             full;
  logic [ByteW-1:0] code_byte_i   = '0;
  logic             end_of_text_i = 1'b0;
  logic             empty;
  logic             pop           = 1'b0;
  logic [CharW-1:0] text_char_o;

  // Stimulus and expected characters
  code_item_t       pending_q[$];
  logic [CharW-1:0] decoded_q[$];
  int unsigned      total_items;
  int unsigned      taken_count = 0;
  int unsigned      err_count   = 0;
  int unsigned      cycle_count = 0;
  int unsigned      stall_count = 0;
  logic             calm;

  // Token state of the model
  logic [3:0]       tok_count   = '0;
  logic [PatW-1:0]  tok_pattern = '0;
  logic             tok_slash   = 1'b0;
  logic             tok_bad     = 1'b0;

  // Code table, earlier entries win on a shared pattern
  string morse_codes [64] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
    "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
    "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
    "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.",
    ".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.", "-.--.-",
    ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-", "..--.-", ".-..-.",
    "...-..-", ".--.-.", "...-.-", "-----.", "-...-.", "-.-..", ".--.--.", "-..--",
    "--..-", "-.--..", "-.-.-", ".-.-.."
  };
  string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@#%^|~{}>*\n";

  morse_code_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_byte_i  (code_byte_i),
    .end_of_text_i(end_of_text_i),
    .empty        (empty),
    .pop          (pop),
    .text_char_o  (text_char_o)
  );

  always #4 clk_i = ~clk_i;

  // No idling on either side inside this window
  assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

  function automatic bit is_blank(logic [ByteW-1:0] b);
    return (b == SpaceByte) || (b >= TabByte && b <= CrByte);
  endfunction

  function automatic logic [ByteW-1:0] any_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? SpaceByte : ByteW'(TabByte + r);
  endfunction

  // First table entry with this length and pattern
  function automatic bit table_lookup(int unsigned n, logic [PatW-1:0] pat,
                                      output logic [CharW-1:0] ch);
    logic [PatW-1:0] p;
    ch = '0;
    foreach (morse_codes[i]) begin
      p = '0;
      for (int k = 0; k < morse_codes[i].len(); k++)
        p = {p[PatW-2:0], morse_codes[i][k] == DashByte};
      if (morse_codes[i].len() == n && p == pat) begin
        ch = CharW'(glyphs[i]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Close the current token; returns 1 when it yields a character
  function automatic bit close_token(output logic [CharW-1:0] ch);
    bit hit;
    hit = 1'b0;
    ch  = '0;
    if (!tok_bad) begin
      if (tok_slash) begin
        ch  = SpaceChar;
        hit = 1'b1;
      end else if (tok_count != 0 && tok_count <= MaxSymbols) begin
        hit = table_lookup(tok_count, tok_pattern, ch);
      end
    end
    tok_count   = '0;
    tok_pattern = '0;
    tok_slash   = 1'b0;
    tok_bad     = 1'b0;
    return hit;
  endfunction

  // Model of one accepted byte
  task automatic decode_byte(logic [ByteW-1:0] b, logic eot);
    logic [CharW-1:0] ch;
    logic [CharW-1:0] spare;
    bit               hit;
    hit = 1'b0;
    if (is_blank(b)) begin
      hit = close_token(ch);
    end else if (b == DotByte || b == DashByte) begin
      if (tok_slash || tok_count >= MaxSymbols || tok_count >= SatCount) begin
        tok_bad = 1'b1;
      end else begin
        tok_pattern = {tok_pattern[PatW-2:0], b == DashByte};
        tok_count   = tok_count + 1'b1;
      end
    end else if (b == SlashByte) begin
      if (tok_slash || tok_count != 0) tok_bad = 1'b1;
      tok_slash = 1'b1;
    end else begin
      tok_bad = 1'b1;
    end
    // end of text flushes whatever is left
    if (eot && !hit) hit = close_token(ch);
    else if (eot) void'(close_token(spare));
    if (hit) decoded_q.push_back(ch);
  endtask

  task automatic add_byte(logic [ByteW-1:0] b, logic eot);
    pending_q.push_back('{code: b, eot: eot});
  endtask

  task automatic add_code(string s, logic eot_last);
    for (int k = 0; k < s.len(); k++)
      add_byte(s[k], eot_last && (k == s.len() - 1));
  endtask

  // Input driver
  always @(posedge clk_i) begin : drive_bytes
    code_item_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(code_byte_i, end_of_text_i);
        taken_count <= taken_count + 1;
      end
      if (!(push && full)) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          nxt = pending_q.pop_front();
          push          <= 1'b1;
          code_byte_i   <= nxt.code;
          end_of_text_i <= nxt.eot;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : check_chars
    logic [CharW-1:0] want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("text_char: expected none, actual %02h", text_char_o);
          err_count <= err_count + 1;
        end else begin
          want = decoded_q.pop_front();
          if (want !== text_char_o) begin
            $error("text_char: expected %02h, actual %02h", want, text_char_o);
            err_count <= err_count + 1;
          end
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ((push && !full) || (pop && !empty)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned sep;

    // Directed: letters, lone slash, every blank, empty token, unknown pattern,
    // mixed slash, stray bytes at both extremes, five-symbol code, end of text on
    // a blank and on a symbol, too long a token, seven-symbol code
    add_code(".-", 1'b0);      add_byte(SpaceByte, 1'b0);
    add_byte(SlashByte, 1'b0); add_byte(TabByte, 1'b0);
    add_code("---.", 1'b0);    add_byte(8'h0A, 1'b0);
    add_code("-/", 1'b0);      add_byte(8'h0B, 1'b0);
    add_byte(8'h00, 1'b0);     add_byte(8'hFF, 1'b0);   add_byte(8'h0C, 1'b0);
    add_code("-.-..", 1'b0);   add_byte(CrByte, 1'b1);
    add_code("--------", 1'b1);
    add_code(".--.--.", 1'b1);

    // Random tokens, mostly well formed
    while (pending_q.size() < NumItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        add_code(morse_codes[$urandom_range(0, 63)], 1'b0);
      end else if (kind < 65) begin
        add_byte(SlashByte, 1'b0);
      end else if (kind < 80) begin
        n = $urandom_range(1, 9);
        repeat (n) add_byte($urandom_range(0, 1) ? DashByte : DotByte, 1'b0);
      end else if (kind < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = $urandom_range(0, 2);
          add_byte((r == 0) ? DotByte : (r == 1) ? DashByte : SlashByte, 1'b0);
        end
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
      // token end: end of text on the last byte, run-on, or blanks
      sep = $urandom_range(0, 99);
      if (sep < 6) begin
        pending_q[pending_q.size() - 1].eot = 1'b1;
      end else if (sep >= 10) begin
        add_byte(any_blank(), sep < 14);
        if (sep >= 90) add_byte(any_blank(), 1'b0);
      end
    end
    total_items = pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all bytes, then all characters, then let the pipe settle
    do @(posedge clk_i); while (taken_count != total_items);
    do @(posedge clk_i); while (decoded_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
